@@ src/wheel_pid_motor_drive_unit_assert.svh @@
// assertion helpers shared by the rtl of the drive unit
`ifndef WHEEL_PID_MOTOR_DRIVE_UNIT_ASSERT_SVH
`define WHEEL_PID_MOTOR_DRIVE_UNIT_ASSERT_SVH

// consequence checked in the same cycle as the trigger
`define WPMD_ASSERT_NOW(name, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

// consequence checked in the cycle after the trigger
`define WPMD_ASSERT_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

@@ src/wpmd_pkg.sv @@
`default_nettype none

package wpmd_pkg;

  // controller size and field widths
  localparam int WHEEL_COUNT = 4;
  localparam int WHEEL_W     = 2;
  localparam int SPEED_W     = 16;
  localparam int DT_W        = 20;
  localparam int DUTY_W      = 12;
  localparam int DIR_W       = 2;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 20;
  localparam int DEADBAND_W  = 15;
  localparam int FRAC_W      = 16;

  localparam logic [WHEEL_W:0] WHEEL_LIMIT = (WHEEL_W + 1)'(WHEEL_COUNT);

  // internal datapath widths
  localparam int ERR_W   = 17;
  localparam int INTEG_W = 22;
  localparam int ACC_W   = 21;
  localparam int DIFF_W  = 18;

  // serial multiplier: two multiplier bits per cycle
  localparam int MUL_A_W   = 36;
  localparam int MUL_B_W   = 20;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W / 2;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  // serial divider: two quotient bits per cycle
  localparam int DIV_RADIX = 2;
  localparam int DIV_N_W   = PROD_W;
  localparam int DIV_D_W   = DT_W;
  localparam int DIV_STEPS = DIV_N_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int SUM_W = PROD_W + 1;

  localparam logic [DT_W-1:0] US_PER_SEC = 20'd1000000;

  // register file
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [GAIN_W-1:0]     PROP_GAIN_RST      = 16'd0;
  localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST     = 16'd0;
  localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST     = 16'd0;
  localparam logic [LIMIT_W-1:0]    INTEGRAL_LIMIT_RST = 20'd76800;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST       = 15'd13;
  localparam logic [DUTY_W-1:0]     PWM_LIMIT_RST      = 12'd1600;

  typedef enum logic [2:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_DEADBAND       = 3'd4,
    REG_PWM_LIMIT      = 3'd5
  } reg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_CLAMP,
    ST_MUL1_GO,
    ST_MUL1,
    ST_MUL2_GO,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV,
    ST_SGN,
    ST_SUM,
    ST_CLIP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ src/wheel_pid_motor_drive_unit.sv @@
// Per-wheel PID speed controller driving an H-bridge.
// Input channel (in_valid/in_ready): wheel, signed Q8.8 commanded and measured
// speed, microseconds since the wheel's last active step. One item is taken at
// a time; in_ready is high only while the controller is idle.
// Output channel (out_valid/out_ready): wheel_out, duty count, direction
// (0 off, 1 forward, 2 reverse). One result per item.
// An active item passes through the bit-serial datapath: two 20-bit shift-add
// multiplies at two bits a cycle followed by a 56-bit restoring divide at two
// bits a cycle. A stop command or an out-of-range wheel skips the datapath and
// gives its result directly.
// The output register holds a finished result while out_ready is low; the
// block finishes its current item and waits with that result until the
// register frees, then takes the next item.
// Reset (rst_n, synchronous, active low) loads the register defaults and
// clears every wheel's integral and stored error.
// Registers on the APB-style port at 4*index: prop_gain, integ_gain,
// deriv_gain, integral_limit, deadband, pwm_limit; write only while idle.
`default_nettype none
`include "wheel_pid_motor_drive_unit_assert.svh"

module wheel_pid_motor_drive_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wpmd_pkg::WHEEL_W-1:0]        in_wheel,
  input  logic signed [wpmd_pkg::SPEED_W-1:0] in_command_speed,
  input  logic signed [wpmd_pkg::SPEED_W-1:0] in_measured_speed,
  input  logic [wpmd_pkg::DT_W-1:0]           in_elapsed_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wpmd_pkg::WHEEL_W-1:0]        out_wheel_out,
  output logic [wpmd_pkg::DUTY_W-1:0]         out_duty,
  output logic [wpmd_pkg::DIR_W-1:0]          out_direction,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wpmd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wpmd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wpmd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import wpmd_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]     prop_gain_r;
  logic [GAIN_W-1:0]     integ_gain_r;
  logic [GAIN_W-1:0]     deriv_gain_r;
  logic [LIMIT_W-1:0]    integral_limit_r;
  logic [DEADBAND_W-1:0] deadband_r;
  logic [DUTY_W-1:0]     pwm_limit_r;
  reg_idx_t              reg_idx;
  logic                  cfg_wr;

  // controller state
  state_t state_r;
  state_t state_nxt;

  // item registers
  logic [WHEEL_W-1:0]        wheel_r;
  logic signed [SPEED_W-1:0] cmd_r;
  logic signed [SPEED_W-1:0] meas_r;
  logic [DT_W-1:0]           dt_r;

  // per-wheel state
  logic signed [ERR_W-1:0]   prev_err_r [WHEEL_COUNT];
  logic signed [INTEG_W-1:0] integ_r    [WHEEL_COUNT];

  // error stage
  logic [SPEED_W:0]        cmd_mag;
  logic                    stop_cmd;
  logic                    in_range;
  logic signed [ERR_W-1:0] err_val;
  logic signed [ERR_W-1:0] e_r;

  // clamp stage
  logic signed [INTEG_W:0]   acc_sum;
  logic signed [INTEG_W:0]   lim_pos;
  logic signed [INTEG_W:0]   lim_neg;
  logic signed [INTEG_W:0]   acc_clamped;
  logic signed [DIFF_W-1:0]  diff_val;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DIFF_W-1:0]  diff_r;

  // magnitudes fed to the multipliers
  logic [ERR_W-1:0]  abs_e;
  logic [ACC_W-1:0]  abs_acc;
  logic [DIFF_W-1:0] abs_diff;

  // serial units
  logic                mul1_start;
  logic                mul2_start;
  logic                div_start;
  logic                mul_ab_start;
  logic [MUL_A_W-1:0]  mul_p_a;
  logic [MUL_B_W-1:0]  mul_p_b;
  logic [MUL_A_W-1:0]  mul_i_a;
  logic [MUL_B_W-1:0]  mul_i_b;
  logic [MUL_A_W-1:0]  mul_d_a;
  logic [MUL_B_W-1:0]  mul_d_b;
  logic [PROD_W-1:0]   prod_p;
  logic [PROD_W-1:0]   prod_i;
  logic [PROD_W-1:0]   prod_d;
  logic                busy_p;
  logic                busy_i;
  logic                busy_d;
  logic [DIV_N_W-1:0]  quo_i;
  logic [DIV_N_W-1:0]  quo_d;
  logic                dbusy_i;
  logic                dbusy_d;

  // sum and clip
  logic signed [SUM_W-1:0] p_s_r;
  logic signed [SUM_W-1:0] i_s_r;
  logic signed [SUM_W-1:0] d_s_r;
  logic signed [SUM_W-1:0] s1_r;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] top;
  logic [DUTY_W-1:0]       clip_duty;

  // result and output register
  logic [DUTY_W-1:0]  res_duty_r;
  dir_t               res_dir_r;
  logic               out_load;
  logic               out_valid_r;
  logic [WHEEL_W-1:0] out_wheel_r;
  logic [DUTY_W-1:0]  out_duty_r;
  dir_t               out_dir_r;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= PROP_GAIN_RST;
      integ_gain_r     <= INTEG_GAIN_RST;
      deriv_gain_r     <= DERIV_GAIN_RST;
      integral_limit_r <= INTEGRAL_LIMIT_RST;
      deadband_r       <= DEADBAND_RST;
      pwm_limit_r      <= PWM_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROP_GAIN:      prop_gain_r      <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     integ_gain_r     <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     deriv_gain_r     <= pwdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit_r <= pwdata[LIMIT_W-1:0];
        REG_DEADBAND:       deadband_r       <= pwdata[DEADBAND_W-1:0];
        REG_PWM_LIMIT:      pwm_limit_r      <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:      prdata = {(APB_DATA_W - GAIN_W)'(0), prop_gain_r};
      REG_INTEG_GAIN:     prdata = {(APB_DATA_W - GAIN_W)'(0), integ_gain_r};
      REG_DERIV_GAIN:     prdata = {(APB_DATA_W - GAIN_W)'(0), deriv_gain_r};
      REG_INTEGRAL_LIMIT: prdata = {(APB_DATA_W - LIMIT_W)'(0), integral_limit_r};
      REG_DEADBAND:       prdata = {(APB_DATA_W - DEADBAND_W)'(0), deadband_r};
      REG_PWM_LIMIT:      prdata = {(APB_DATA_W - DUTY_W)'(0), pwm_limit_r};
      default:            prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_ERR;
      ST_ERR:     state_nxt = (!in_range || stop_cmd) ? ST_DONE : ST_CLAMP;
      ST_CLAMP:   state_nxt = ST_MUL1_GO;
      ST_MUL1_GO: state_nxt = ST_MUL1;
      ST_MUL1:    if (!busy_p && !busy_i && !busy_d) state_nxt = ST_MUL2_GO;
      ST_MUL2_GO: state_nxt = ST_MUL2;
      ST_MUL2:    if (!busy_i && !busy_d) state_nxt = ST_DIV_GO;
      ST_DIV_GO:  state_nxt = ST_DIV;
      ST_DIV:     if (!dbusy_i && !dbusy_d) state_nxt = ST_SGN;
      ST_SGN:     state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_CLIP;
      ST_CLIP:    state_nxt = ST_DONE;
      ST_DONE:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    mul1_start = 1'b0;
    mul2_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE:    in_ready   = 1'b1;
      ST_MUL1_GO: mul1_start = 1'b1;
      ST_MUL2_GO: mul2_start = 1'b1;
      ST_DIV_GO:  div_start  = 1'b1;
      ST_DONE:    out_load   = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      wheel_r <= in_wheel;
      cmd_r   <= in_command_speed;
      meas_r  <= in_measured_speed;
      dt_r    <= in_elapsed_us;
    end
  end

  // command magnitude, deadband test and speed error
  always_comb begin
    cmd_mag  = cmd_r[SPEED_W-1] ? ((SPEED_W + 1)'(0) - {cmd_r[SPEED_W-1], cmd_r})
                                : {1'b0, cmd_r};
    stop_cmd = (cmd_mag <= {2'b00, deadband_r});
    in_range = ({1'b0, wheel_r} < WHEEL_LIMIT);
    err_val  = cmd_r[SPEED_W-1] ? ({meas_r[SPEED_W-1], meas_r} - {cmd_r[SPEED_W-1], cmd_r})
                                : ({cmd_r[SPEED_W-1], cmd_r} - {meas_r[SPEED_W-1], meas_r});
  end

  // integral update with symmetric clamp, error change
  always_comb begin
    acc_sum  = {integ_r[wheel_r][INTEG_W-1], integ_r[wheel_r]}
             + {{(INTEG_W + 1 - ERR_W){e_r[ERR_W-1]}}, e_r};
    lim_pos  = {(INTEG_W + 1 - LIMIT_W)'(0), integral_limit_r};
    lim_neg  = (INTEG_W + 1)'(0) - lim_pos;
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_sum;
    end
    diff_val = {e_r[ERR_W-1], e_r}
             - {prev_err_r[wheel_r][ERR_W-1], prev_err_r[wheel_r]};
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ERR) begin
      e_r <= err_val;
    end
    if (state_r == ST_CLAMP) begin
      acc_r  <= acc_clamped[ACC_W-1:0];
      diff_r <= diff_val;
    end
  end

  // per-wheel integral and stored error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        prev_err_r[i] <= '0;
        integ_r[i]    <= '0;
      end
    end else if (state_r == ST_ERR && in_range && stop_cmd) begin
      integ_r[wheel_r] <= '0;
    end else if (state_r == ST_CLAMP) begin
      integ_r[wheel_r]    <= acc_clamped[INTEG_W-1:0];
      prev_err_r[wheel_r] <= e_r;
    end
  end

  // operand magnitudes, signs stay in e_r, acc_r and diff_r
  assign abs_e    = e_r[ERR_W-1]    ? ERR_W'(0) - e_r      : e_r;
  assign abs_acc  = acc_r[ACC_W-1]  ? ACC_W'(0) - acc_r    : acc_r;
  assign abs_diff = diff_r[DIFF_W-1] ? DIFF_W'(0) - diff_r : diff_r;

  // first pass multiplies by the gains, second pass by time scale
  assign mul_ab_start = mul1_start || mul2_start;
  assign mul_p_a = {(MUL_A_W - ERR_W)'(0), abs_e};
  assign mul_p_b = {(MUL_B_W - GAIN_W)'(0), prop_gain_r};
  assign mul_i_a = mul2_start ? prod_i[MUL_A_W-1:0] : {(MUL_A_W - ACC_W)'(0), abs_acc};
  assign mul_i_b = mul2_start ? dt_r : {(MUL_B_W - GAIN_W)'(0), integ_gain_r};
  assign mul_d_a = mul2_start ? prod_d[MUL_A_W-1:0] : {(MUL_A_W - DIFF_W)'(0), abs_diff};
  assign mul_d_b = mul2_start ? US_PER_SEC : {(MUL_B_W - GAIN_W)'(0), deriv_gain_r};

  wpmd_ser_mul u_mul_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul1_start),
    .mul_a   (mul_p_a),
    .mul_b   (mul_p_b),
    .busy    (busy_p),
    .product (prod_p)
  );

  wpmd_ser_mul u_mul_i (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_ab_start),
    .mul_a   (mul_i_a),
    .mul_b   (mul_i_b),
    .busy    (busy_i),
    .product (prod_i)
  );

  wpmd_ser_mul u_mul_d (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_ab_start),
    .mul_a   (mul_d_a),
    .mul_b   (mul_d_b),
    .busy    (busy_d),
    .product (prod_d)
  );

  // integral term scaled down to seconds, derivative term scaled by time
  wpmd_ser_div u_div_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_i),
    .divisor  (US_PER_SEC),
    .busy     (dbusy_i),
    .quotient (quo_i)
  );

  wpmd_ser_div u_div_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_d),
    .divisor  (dt_r),
    .busy     (dbusy_d),
    .quotient (quo_d)
  );

  // clip the total to the duty range
  always_comb begin
    total = s1_r + d_s_r;
    top   = {(SUM_W - DUTY_W - FRAC_W)'(0), pwm_limit_r, FRAC_W'(0)};
    if (total[SUM_W-1]) begin
      clip_duty = '0;
    end else if (total > top) begin
      clip_duty = pwm_limit_r;
    end else begin
      clip_duty = total[FRAC_W+DUTY_W-1:FRAC_W];
    end
  end

  // signed terms, truncated toward zero, and their sum
  always_ff @(posedge clk) begin
    if (state_r == ST_SGN) begin
      p_s_r <= e_r[ERR_W-1] ? SUM_W'(0) - {1'b0, prod_p} : {1'b0, prod_p};
      i_s_r <= acc_r[ACC_W-1] ? SUM_W'(0) - {1'b0, quo_i} : {1'b0, quo_i};
      if (dt_r == '0) begin
        d_s_r <= '0;
      end else begin
        d_s_r <= diff_r[DIFF_W-1] ? SUM_W'(0) - {1'b0, quo_d} : {1'b0, quo_d};
      end
    end
    if (state_r == ST_SUM) begin
      s1_r <= p_s_r + i_s_r;
    end
  end

  // result before the output register
  always_ff @(posedge clk) begin
    if (state_r == ST_ERR) begin
      res_duty_r <= '0;
      res_dir_r  <= DIR_OFF;
    end else if (state_r == ST_CLIP) begin
      res_duty_r <= clip_duty;
      res_dir_r  <= cmd_r[SPEED_W-1] ? DIR_REV : DIR_FWD;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_wheel_r <= wheel_r;
      out_duty_r  <= res_duty_r;
      out_dir_r   <= res_dir_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_wheel_out = out_wheel_r;
  assign out_duty      = out_duty_r;
  assign out_direction = out_dir_r;

  // checks
  `WPMD_ASSERT_NEXT(a_integ_clamped, state_r == ST_CLAMP, (acc_r <= $past(lim_pos)) && (acc_r >= $past(lim_neg)), "integral outside its limit")
  `WPMD_ASSERT_NEXT(a_duty_limit, state_r == ST_CLIP, res_duty_r <= $past(pwm_limit_r), "duty above pwm limit")
  `WPMD_ASSERT_NOW(a_off_no_duty, out_valid && (out_direction == DIR_OFF), out_duty == '0, "duty with bridge off")
  `WPMD_ASSERT_NOW(a_mul_lanes, state_r == ST_MUL1, (busy_i == busy_d) && (busy_i == busy_p), "multiplier lanes out of step")
  `WPMD_ASSERT_NEXT(a_result_held, (state_r == ST_DONE) && out_valid_r && !out_ready, (state_r == ST_DONE) && out_valid_r, "result dropped while output stalled")

endmodule

`default_nettype wire

@@ src/wpmd_ser_mul.sv @@
`default_nettype none

module wpmd_ser_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wpmd_pkg::MUL_A_W-1:0]  mul_a,
  input  logic [wpmd_pkg::MUL_B_W-1:0]  mul_b,
  output logic                          busy,
  output logic [wpmd_pkg::PROD_W-1:0]   product
);
  import wpmd_pkg::*;

  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_A_W-1:0]   a_r;
  logic [MUL_A_W+1:0]   a3_r;
  logic [MUL_A_W-1:0]   hi_r;
  logic [MUL_B_W-1:0]   lo_r;
  logic [MUL_A_W+1:0]   pp;
  logic [MUL_A_W+1:0]   part_sum;

  assign busy    = (cnt_r != '0);
  assign product = {hi_r, lo_r};

  // partial product for the low two multiplier bits
  always_comb begin
    case (lo_r[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = {2'b00, a_r};
      2'd2:    pp = {1'b0, a_r, 1'b0};
      default: pp = a3_r;
    endcase
    part_sum = {2'b00, hi_r} + pp;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= MUL_CNT_W'(MUL_STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // shift-add datapath, low product bits shift in behind the multiplier
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= mul_a;
      a3_r <= {2'b00, mul_a} + {1'b0, mul_a, 1'b0};
      hi_r <= '0;
      lo_r <= mul_b;
    end else if (busy) begin
      hi_r <= part_sum[MUL_A_W+1:2];
      lo_r <= {part_sum[1:0], lo_r[MUL_B_W-1:2]};
    end
  end

endmodule

`default_nettype wire

@@ src/wpmd_ser_div.sv @@
`default_nettype none

module wpmd_ser_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wpmd_pkg::DIV_N_W-1:0]  dividend,
  input  logic [wpmd_pkg::DIV_D_W-1:0]  divisor,
  output logic                          busy,
  output logic [wpmd_pkg::DIV_N_W-1:0]  quotient
);
  import wpmd_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   div_d_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_N_W-1:0]   quo_r;
  logic [DIV_D_W-1:0]   rem_v;
  logic [DIV_N_W-1:0]   quo_v;
  logic [DIV_D_W:0]     trial;
  logic                 take;

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

  // two restoring steps per cycle, dividend bits leave as quotient bits enter
  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    trial = '0;
    take  = 1'b0;
    for (int k = 0; k < DIV_RADIX; k++) begin
      trial = {rem_v, quo_v[DIV_N_W-1]};
      take  = (trial >= {1'b0, div_d_r});
      rem_v = take ? DIV_D_W'(trial - {1'b0, div_d_r}) : trial[DIV_D_W-1:0];
      quo_v = {quo_v[DIV_N_W-2:0], take};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      div_d_r <= divisor;
      rem_r   <= '0;
      quo_r   <= dividend;
    end else if (busy) begin
      rem_r <= rem_v;
      quo_r <= quo_v;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import wpmd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int SHOWN_ERRORS  = 10;

  // one speed-loop step for a wheel
  typedef struct {
    logic [WHEEL_W-1:0]        wheel;
    logic signed [SPEED_W-1:0] cmd;
    logic signed [SPEED_W-1:0] meas;
    logic [DT_W-1:0]           dt;
  } wheel_step_t;

  // bridge drive produced for one step
  typedef struct {
    logic [WHEEL_W-1:0] wheel;
    logic [DUTY_W-1:0]  duty;
    dir_t               dir;
  } bridge_drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [WHEEL_W-1:0]        in_wheel = '0;
  logic signed [SPEED_W-1:0] in_command_speed = '0;
  logic signed [SPEED_W-1:0] in_measured_speed = '0;
  logic [DT_W-1:0]           in_elapsed_us = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [WHEEL_W-1:0]        out_wheel_out;
  logic [DUTY_W-1:0]         out_duty;
  logic [DIR_W-1:0]          out_direction;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]     paddr = '0;
  logic [APB_DATA_W-1:0]     pwdata = '0;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;

  wheel_pid_motor_drive_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_wheel          (in_wheel),
    .in_command_speed  (in_command_speed),
    .in_measured_speed (in_measured_speed),
    .in_elapsed_us     (in_elapsed_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wheel_out     (out_wheel_out),
    .out_duty          (out_duty),
    .out_direction     (out_direction),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // controller settings and per-wheel loop state as the block should hold them
  logic [GAIN_W-1:0]         kp_cfg;
  logic [GAIN_W-1:0]         ki_cfg;
  logic [GAIN_W-1:0]         kd_cfg;
  logic [LIMIT_W-1:0]        ilim_cfg;
  logic [DEADBAND_W-1:0]     dband_cfg;
  logic [DUTY_W-1:0]         pwm_cfg;
  logic signed [ERR_W-1:0]   last_err [WHEEL_COUNT];
  logic signed [INTEG_W-1:0] err_sum [WHEEL_COUNT];

  wheel_step_t   pending_steps [$];
  bridge_drive_t expected_drive [$];
  wheel_step_t   next_step;
  wheel_step_t   taken_step;
  bridge_drive_t want;

  logic in_fire = 1'b0;
  int   steps_queued = 0;
  int   drives_seen = 0;
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   cycle_count = 0;

  always #10 clk = ~clk;

  // pid step: integral clamp, three terms in q16.16 counts, duty clamp
  function automatic bridge_drive_t predict_drive(wheel_step_t s);
    bridge_drive_t r;
    longint mag;
    longint err;
    longint acc;
    longint lim;
    longint total;
    longint ceil_q;
    r.wheel = s.wheel;
    r.duty = '0;
    r.dir = DIR_OFF;
    if (s.wheel >= WHEEL_COUNT) return r;
    mag = (s.cmd < 0) ? -longint'(s.cmd) : longint'(s.cmd);
    // stop command clears the integral, keeps the stored error
    if (mag <= longint'(dband_cfg)) begin
      err_sum[s.wheel] = '0;
      return r;
    end
    err = (s.cmd < 0) ? mag + longint'(s.meas) : mag - longint'(s.meas);
    lim = longint'(ilim_cfg);
    acc = longint'(err_sum[s.wheel]) + err;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    err_sum[s.wheel] = acc[INTEG_W-1:0];
    total = longint'(kp_cfg) * err;
    total += (longint'(ki_cfg) * acc * longint'(s.dt)) / longint'(US_PER_SEC);
    // no derivative term when no time has passed
    if (s.dt != 0)
      total += (longint'(kd_cfg) * (err - longint'(last_err[s.wheel])) *
                longint'(US_PER_SEC)) / longint'(s.dt);
    last_err[s.wheel] = err[ERR_W-1:0];
    ceil_q = longint'(pwm_cfg) << FRAC_W;
    if (total > ceil_q) total = ceil_q;
    if (total < 0) total = 0;
    r.duty = total[FRAC_W +: DUTY_W];
    r.dir = (s.cmd < 0) ? DIR_REV : DIR_FWD;
    return r;
  endfunction

  // mostly tracking steps near the command, some stops and raw noise
  function automatic wheel_step_t random_step();
    wheel_step_t s;
    int pick;
    int mag;
    int m;
    pick = $urandom_range(99);
    s.wheel = WHEEL_W'($urandom_range(WHEEL_COUNT - 1));
    s.meas = SPEED_W'($urandom);
    s.dt = DT_W'($urandom_range(20000, 2000));
    if (pick < 10) begin
      mag = $urandom_range(int'(dband_cfg));
      s.cmd = SPEED_W'($urandom_range(1) ? -mag : mag);
    end else if (pick < 25) begin
      s.cmd = SPEED_W'($urandom);
      s.dt = DT_W'($urandom);
    end else begin
      mag = $urandom_range(32767, int'(dband_cfg) + 1);
      s.cmd = SPEED_W'($urandom_range(1) ? -mag : mag);
      m = $urandom_range(2048);
      m = int'(s.cmd) + m - 1024;
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      s.meas = m[SPEED_W-1:0];
      pick = $urandom_range(99);
      if (pick < 5) s.dt = '0;
      else if (pick < 10) s.dt = DT_W'($urandom_range(1048575, 1000001));
    end
    return s;
  endfunction

  task automatic flag_mismatch(string why, bridge_drive_t exp_drive);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS)
      $display("mismatch (%s): expected wheel %0d duty %0d dir %0d, got wheel %0d duty %0d dir %0d",
               why, exp_drive.wheel, exp_drive.duty, exp_drive.dir,
               out_wheel_out, out_duty, out_direction);
  endtask

  // item driver: next pending item at the falling edge, random sender gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_step = pending_steps.pop_front();
          in_valid <= 1'b1;
          in_wheel <= next_step.wheel;
          in_command_speed <= next_step.cmd;
          in_measured_speed <= next_step.meas;
          in_elapsed_us <= next_step.dt;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        taken_step.wheel = in_wheel;
        taken_step.cmd = in_command_speed;
        taken_step.meas = in_measured_speed;
        taken_step.dt = in_elapsed_us;
        expected_drive.push_back(predict_drive(taken_step));
      end
      if (out_valid && out_ready) begin
        drives_seen++;
        if (expected_drive.size() == 0) begin
          want.wheel = '0;
          want.duty = '0;
          want.dir = DIR_OFF;
          flag_mismatch("result with nothing outstanding", want);
        end else begin
          want = expected_drive.pop_front();
          if (out_wheel_out !== want.wheel) flag_mismatch("wheel_out", want);
          else if (out_duty !== want.duty) flag_mismatch("duty", want);
          else if (out_direction !== want.dir) flag_mismatch("direction", want);
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_step(int w, int cmd, int meas, int dt);
    wheel_step_t s;
    s.wheel = WHEEL_W'(w);
    s.cmd = SPEED_W'(cmd);
    s.meas = SPEED_W'(meas);
    s.dt = DT_W'(dt);
    pending_steps.push_back(s);
    steps_queued++;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      pending_steps.push_back(random_step());
      steps_queued++;
    end
  endtask

  // wait until every queued item has its result back, end on a rising edge
  task automatic settle();
    @(negedge clk);
    while (drives_seen < steps_queued) @(negedge clk);
    repeat (4) @(negedge clk);
    @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, done when pready is seen
  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PROP_GAIN:      kp_cfg = val[GAIN_W-1:0];
      REG_INTEG_GAIN:     ki_cfg = val[GAIN_W-1:0];
      REG_DERIV_GAIN:     kd_cfg = val[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT: ilim_cfg = val[LIMIT_W-1:0];
      REG_DEADBAND:       dband_cfg = val[DEADBAND_W-1:0];
      REG_PWM_LIMIT:      pwm_cfg = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int kp, int ki, int kd, int lim, int db, int pwm);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_INTEGRAL_LIMIT, lim);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_PWM_LIMIT, pwm);
  endtask

  initial begin
    kp_cfg = PROP_GAIN_RST;
    ki_cfg = INTEG_GAIN_RST;
    kd_cfg = DERIV_GAIN_RST;
    ilim_cfg = INTEGRAL_LIMIT_RST;
    dband_cfg = DEADBAND_RST;
    pwm_cfg = PWM_LIMIT_RST;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      last_err[i] = '0;
      err_sum[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults give zero duty with the direction still set
    queue_step(0, 1280, 0, 10000);
    settle();
    set_config(16'h0300, 16'h0200, 16'h0040, 76800, 13, 1600);
    // deadband edges
    queue_step(1, 13, 0, 10000);
    queue_step(1, -13, 0, 10000);
    queue_step(1, 14, 0, 10000);
    queue_step(1, -14, 500, 10000);
    // speed extremes, longest elapsed time, zero elapsed time
    queue_step(2, 32767, -32768, 1048575);
    queue_step(2, -32768, 32767, 0);
    queue_step(3, -32768, -32768, 1);
    queue_step(3, 0, 0, 0);
    queue_step(0, 32767, 32767, 1048575);
    // drive the integral into its clamp
    repeat (3) queue_step(0, 16384, -16384, 500);
    // stop keeps the stored error for the next derivative
    queue_step(0, 5, 0, 10000);
    queue_step(0, 256, 0, 10000);
    queue_step(1, -20000, 20000, 7);
    settle();
    // limit dropped below a stored integral
    write_reg(REG_INTEGRAL_LIMIT, 1000);
    queue_step(2, 512, 512, 10000);
    queue_step(2, -600, 0, 3000);
    settle();
    // widest deadband and zero duty ceiling
    write_reg(REG_DEADBAND, 32767);
    write_reg(REG_PWM_LIMIT, 0);
    queue_step(3, -32768, 0, 10000);
    queue_step(3, 32767, 0, 10000);
    settle();

    // random, no idling
    set_config(16'h0200, 16'h0100, 16'h0008, 76800, 13, 1600);
    queue_random(110);
    settle();

    // random, sender idle, gains and limits at their top, zero deadband, drained midway
    send_idle_pct = 62;
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 0, 4095);
    queue_random(55);
    settle();
    queue_random(55);
    settle();

    // random, receiver stalls, zero proportional gain and zero integral limit
    send_idle_pct = 0;
    recv_stall_pct = 62;
    set_config(16'h0000, 16'h0800, 16'h0400, 0, 400, 2500);
    queue_random(110);
    settle();

    // random, both sides idle now and then
    send_idle_pct = 12;
    recv_stall_pct = 12;
    set_config(16'h1000, 16'h0040, 16'h0000, 300000, 1, 4000);
    queue_random(105);
    settle();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_drive.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
